FILE: src/hsw_pkg.sv
// Shared types, constants and saturating Q.16 helpers for the shallow water HLLC flux pipeline.
// Used by hsw_mul, hsw_div, hsw_sqrt and hllc_shallow_water_flux. No dependencies.
`default_nettype none

package hsw_pkg;

  typedef logic signed [63:0] q_t;

  localparam q_t QLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam q_t QONE = 64'sd65536;
  localparam logic signed [64:0] QLIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

  localparam logic [30:0] GRAV_RST = 31'd642908;

  localparam int IN_W  = 192;
  localparam int OUT_W = 144;
  localparam int USR_W = 3;

  // unit latencies in cycles
  localparam int MUL_LAT  = 4;
  localparam int DIV_NST  = 16;
  localparam int DIV_SPS  = 4;
  localparam int DIV_LAT  = DIV_NST + 2;
  localparam int SQRT_NST = 10;
  localparam int SQRT_SPS = 4;
  localparam int SQRT_LAT = SQRT_NST + 1;

  localparam int NPH = 15;
  localparam int PH_LAT [NPH] = '{MUL_LAT, SQRT_LAT, MUL_LAT, DIV_LAT, MUL_LAT, DIV_LAT,
                                  DIV_LAT, SQRT_LAT, MUL_LAT, MUL_LAT, MUL_LAT, DIV_LAT,
                                  DIV_LAT, MUL_LAT, MUL_LAT};

  typedef enum logic [1:0] {
    REG_LEFT  = 2'd0,
    REG_LSTAR = 2'd1,
    REG_RSTAR = 2'd2,
    REG_RIGHT = 2'd3
  } region_t;

  // everything one interface carries down the pipeline
  typedef struct packed {
    logic    vld;
    logic    yax;
    logic    ok;
    logic    shl;
    logic    shr;
    region_t rg;
    q_t dl, dr, unl, utl, unr, utr;
    q_t gdl, gdr, fml, fmr, ddl, ddr;
    q_t cl, cr, tq, tt;
    q_t fxl, ftl, fxr, ftr;
    q_t hs, pl, pr, wl, wr, vl, vr;
    q_t ql, qr, sl, sr, a, b, num, den, ss;
    q_t s, d, un, ut, fm, fx, ft, hn, sd, hst;
    q_t e1, e2, e3;
  } st_t;

  function automatic q_t clampv(input logic signed [64:0] v);
    q_t res;
    if (v > QLIM65) res = QLIM;
    else if (v < -QLIM65) res = -QLIM;
    else res = v[63:0];
    return res;
  endfunction

  function automatic q_t qadd(input q_t x, input q_t y);
    return clampv($signed({x[63], x}) + $signed({y[63], y}));
  endfunction

  function automatic q_t qsub(input q_t x, input q_t y);
    return clampv($signed({x[63], x}) - $signed({y[63], y}));
  endfunction

  // products with 0.5 and 0.25 truncate the magnitude
  function automatic q_t qhalf(input q_t x);
    return x[63] ? -((-x) >>> 1) : (x >>> 1);
  endfunction

  function automatic q_t qquarter(input q_t x);
    return x[63] ? -((-x) >>> 2) : (x >>> 2);
  endfunction

  function automatic logic [47:0] out48(input q_t x);
    logic [47:0] res;
    if (x > OUT_MAX) res = 48'h7FFF_FFFF_FFFF;
    else if (x < OUT_MIN) res = 48'h8000_0000_0000;
    else res = x[47:0];
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/hllc_shallow_water_flux.sv
// HLLC flux of the 2-D shallow water equations: fifteen unit phases plus an output register.
// One beat accepted per cycle while the output register is empty or being taken.
// Each beat goes through five divider passes (star depth estimate, shock factor twice,
// contact speed, star depth), two square roots and eight multiplies. A stalled output
// holds the whole pipeline. Reset (synchronous) empties it and sets gravity to 9.81;
// no clearing pass is needed.
// Depends on hsw_pkg, hsw_mul, hsw_div, hsw_sqrt.
`default_nettype none

module hllc_shallow_water_flux import hsw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [30:0]       cfg_data,    // gravity
  input  logic              in_tvalid,
  output logic              in_tready,
  // left_depth[30:0], left_vel_x[62:31], left_vel_y[94:63], right_depth[125:95],
  // right_vel_x[157:126], right_vel_y[189:158], zero pad
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tuser,    // operation
  output logic              out_tvalid,
  input  logic              out_tready,
  // flux_mass[47:0], flux_xmom[95:48], flux_ymom[143:96]
  output logic [OUT_W-1:0]  out_tdata,
  output logic [USR_W-1:0]  out_tuser    // region[1:0], valid_res[2]
);

  logic             en;
  logic [30:0]      grav_r;
  q_t               gq;
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;
  logic [USR_W-1:0] out_tuser_r;

  st_t ph_in  [NPH];
  st_t ph_out [NPH];

  q_t   vxl, vyl, vxr, vyr;
  q_t   u0 [6];
  q_t   u1 [2];
  q_t   u2 [7];
  q_t   u3q;
  logic u3dz;
  q_t   u4 [2];
  q_t   u5q [2];
  logic u5dz [2];
  q_t   u6q [2];
  logic u6dz [2];
  q_t   u7 [2];
  q_t   u8 [2];
  q_t   u9 [2];
  q_t   u10 [2];
  q_t   u11q;
  logic u11dz;
  q_t   u12q;
  logic u12dz;
  q_t   u13 [4];
  q_t   u14 [3];
  q_t   m9a, m9b;
  logic star12, star13, star_fin, left12;
  q_t   fin_m, fin_x, fin_t;
  st_t  lst;

  // advance when the output register is empty or being taken
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign gq        = q_t'({33'b0, grav_r});

  always_ff @(posedge clk) begin
    if (!rst_n) grav_r <= GRAV_RST;
    else if (cfg_valid) grav_r <= cfg_data;
  end

  // aligned delay lines that carry each item beside the units of its phase
  for (genvar k = 0; k < NPH; k++) begin : g_ph
    localparam int L = PH_LAT[k];
    st_t line_r [L];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        for (int j = 0; j < L; j++) line_r[j].vld <= 1'b0;
      end else if (en) begin
        line_r[0] <= ph_in[k];
        for (int j = 1; j < L; j++) line_r[j] <= line_r[j-1];
      end
    end
    assign ph_out[k] = line_r[L-1];
  end

  // entry: unpack and pick normal and tangential velocities
  always_comb begin
    vxl = q_t'($signed(in_tdata[62:31]));
    vyl = q_t'($signed(in_tdata[94:63]));
    vxr = q_t'($signed(in_tdata[157:126]));
    vyr = q_t'($signed(in_tdata[189:158]));
    ph_in[0]     = '0;
    ph_in[0].vld = in_tvalid;
    ph_in[0].yax = in_tuser;
    ph_in[0].ok  = 1'b1;
    ph_in[0].dl  = q_t'({33'b0, in_tdata[30:0]});
    ph_in[0].dr  = q_t'({33'b0, in_tdata[125:95]});
    ph_in[0].unl = in_tuser ? vyl : vxl;
    ph_in[0].utl = in_tuser ? vxl : vyl;
    ph_in[0].unr = in_tuser ? vyr : vxr;
    ph_in[0].utr = in_tuser ? vxr : vyr;
  end

  // g*h, h*un, h*h
  hsw_mul u_m0_0 (.clk(clk), .en(en), .a(gq),           .b(ph_in[0].dl),  .p(u0[0]));
  hsw_mul u_m0_1 (.clk(clk), .en(en), .a(gq),           .b(ph_in[0].dr),  .p(u0[1]));
  hsw_mul u_m0_2 (.clk(clk), .en(en), .a(ph_in[0].dl),  .b(ph_in[0].unl), .p(u0[2]));
  hsw_mul u_m0_3 (.clk(clk), .en(en), .a(ph_in[0].dr),  .b(ph_in[0].unr), .p(u0[3]));
  hsw_mul u_m0_4 (.clk(clk), .en(en), .a(ph_in[0].dl),  .b(ph_in[0].dl),  .p(u0[4]));
  hsw_mul u_m0_5 (.clk(clk), .en(en), .a(ph_in[0].dr),  .b(ph_in[0].dr),  .p(u0[5]));

  always_comb begin
    ph_in[1]     = ph_out[0];
    ph_in[1].gdl = u0[0];
    ph_in[1].gdr = u0[1];
    ph_in[1].fml = u0[2];
    ph_in[1].fmr = u0[3];
    ph_in[1].ddl = u0[4];
    ph_in[1].ddr = u0[5];
  end

  // celerities
  hsw_sqrt u_s1_0 (.clk(clk), .en(en), .a(ph_in[1].gdl), .r(u1[0]));
  hsw_sqrt u_s1_1 (.clk(clk), .en(en), .a(ph_in[1].gdr), .r(u1[1]));

  always_comb begin
    ph_in[2]    = ph_out[1];
    ph_in[2].cl = u1[0];
    ph_in[2].cr = u1[1];
    ph_in[2].tq = qadd(qhalf(qadd(u1[0], u1[1])),
                       qquarter(qsub(ph_out[1].unl, ph_out[1].unr)));
  end

  hsw_mul u_m2_0 (.clk(clk), .en(en), .a(ph_in[2].tq),  .b(ph_in[2].tq),  .p(u2[0]));
  hsw_mul u_m2_1 (.clk(clk), .en(en), .a(ph_in[2].fml), .b(ph_in[2].unl), .p(u2[1]));
  hsw_mul u_m2_2 (.clk(clk), .en(en), .a(ph_in[2].fml), .b(ph_in[2].utl), .p(u2[2]));
  hsw_mul u_m2_3 (.clk(clk), .en(en), .a(ph_in[2].fmr), .b(ph_in[2].unr), .p(u2[3]));
  hsw_mul u_m2_4 (.clk(clk), .en(en), .a(ph_in[2].fmr), .b(ph_in[2].utr), .p(u2[4]));
  hsw_mul u_m2_5 (.clk(clk), .en(en), .a(gq),           .b(ph_in[2].ddl), .p(u2[5]));
  hsw_mul u_m2_6 (.clk(clk), .en(en), .a(gq),           .b(ph_in[2].ddr), .p(u2[6]));

  always_comb begin
    ph_in[3]     = ph_out[2];
    ph_in[3].tt  = u2[0];
    ph_in[3].fxl = qadd(u2[1], qhalf(u2[5]));
    ph_in[3].ftl = u2[2];
    ph_in[3].fxr = qadd(u2[3], qhalf(u2[6]));
    ph_in[3].ftr = u2[4];
  end

  // star depth estimate
  hsw_div u_d3 (.clk(clk), .en(en), .a(ph_in[3].tt), .b(gq), .q(u3q), .dz(u3dz));

  always_comb begin
    ph_in[4]     = ph_out[3];
    ph_in[4].hs  = u3q;
    ph_in[4].ok  = ph_out[3].ok && !u3dz;
    ph_in[4].shl = (u3q > ph_out[3].dl);
    ph_in[4].shr = (u3q > ph_out[3].dr);
    ph_in[4].pl  = qhalf(qadd(u3q, ph_out[3].dl));
    ph_in[4].pr  = qhalf(qadd(u3q, ph_out[3].dr));
  end

  hsw_mul u_m4_0 (.clk(clk), .en(en), .a(ph_in[4].pl), .b(ph_in[4].hs), .p(u4[0]));
  hsw_mul u_m4_1 (.clk(clk), .en(en), .a(ph_in[4].pr), .b(ph_in[4].hs), .p(u4[1]));

  always_comb begin
    ph_in[5]    = ph_out[4];
    ph_in[5].wl = u4[0];
    ph_in[5].wr = u4[1];
  end

  hsw_div u_d5_0 (.clk(clk), .en(en), .a(ph_in[5].wl), .b(ph_in[5].dl), .q(u5q[0]),
                  .dz(u5dz[0]));
  hsw_div u_d5_1 (.clk(clk), .en(en), .a(ph_in[5].wr), .b(ph_in[5].dr), .q(u5q[1]),
                  .dz(u5dz[1]));

  always_comb begin
    ph_in[6]    = ph_out[5];
    ph_in[6].vl = u5q[0];
    ph_in[6].vr = u5q[1];
    // a dry side only matters behind a shock
    ph_in[6].ok = ph_out[5].ok && !(ph_out[5].shl && u5dz[0]) && !(ph_out[5].shr && u5dz[1]);
  end

  hsw_div u_d6_0 (.clk(clk), .en(en), .a(ph_in[6].vl), .b(ph_in[6].dl), .q(u6q[0]),
                  .dz(u6dz[0]));
  hsw_div u_d6_1 (.clk(clk), .en(en), .a(ph_in[6].vr), .b(ph_in[6].dr), .q(u6q[1]),
                  .dz(u6dz[1]));

  always_comb begin
    ph_in[7]    = ph_out[6];
    ph_in[7].vl = u6q[0];
    ph_in[7].vr = u6q[1];
    ph_in[7].ok = ph_out[6].ok && !(ph_out[6].shl && u6dz[0]) && !(ph_out[6].shr && u6dz[1]);
  end

  hsw_sqrt u_s7_0 (.clk(clk), .en(en), .a(ph_in[7].vl), .r(u7[0]));
  hsw_sqrt u_s7_1 (.clk(clk), .en(en), .a(ph_in[7].vr), .r(u7[1]));

  always_comb begin
    ph_in[8]    = ph_out[7];
    ph_in[8].ql = ph_out[7].shl ? u7[0] : QONE;
    ph_in[8].qr = ph_out[7].shr ? u7[1] : QONE;
  end

  hsw_mul u_m8_0 (.clk(clk), .en(en), .a(ph_in[8].cl), .b(ph_in[8].ql), .p(u8[0]));
  hsw_mul u_m8_1 (.clk(clk), .en(en), .a(ph_in[8].cr), .b(ph_in[8].qr), .p(u8[1]));

  always_comb begin
    ph_in[9]    = ph_out[8];
    ph_in[9].sl = qsub(ph_out[8].unl, u8[0]);
    ph_in[9].sr = qadd(ph_out[8].unr, u8[1]);
    m9a         = qsub(ph_in[9].unr, ph_in[9].sr);
    m9b         = qsub(ph_in[9].unl, ph_in[9].sl);
  end

  hsw_mul u_m9_0 (.clk(clk), .en(en), .a(ph_in[9].dr), .b(m9a), .p(u9[0]));
  hsw_mul u_m9_1 (.clk(clk), .en(en), .a(ph_in[9].dl), .b(m9b), .p(u9[1]));

  always_comb begin
    ph_in[10]   = ph_out[9];
    ph_in[10].a = u9[0];
    ph_in[10].b = u9[1];
  end

  hsw_mul u_m10_0 (.clk(clk), .en(en), .a(ph_in[10].sl), .b(ph_in[10].a), .p(u10[0]));
  hsw_mul u_m10_1 (.clk(clk), .en(en), .a(ph_in[10].sr), .b(ph_in[10].b), .p(u10[1]));

  always_comb begin
    ph_in[11]     = ph_out[10];
    ph_in[11].num = qsub(u10[0], u10[1]);
    ph_in[11].den = qsub(ph_out[10].a, ph_out[10].b);
  end

  // contact speed
  hsw_div u_d11 (.clk(clk), .en(en), .a(ph_in[11].num), .b(ph_in[11].den), .q(u11q),
                 .dz(u11dz));

  always_comb begin
    ph_in[12]    = ph_out[11];
    ph_in[12].ss = u11q;
    if (!ph_out[11].sl[63])                             ph_in[12].rg = REG_LEFT;
    else if (ph_out[11].sr[63] || ph_out[11].sr == '0)  ph_in[12].rg = REG_RIGHT;
    else if (!u11q[63])                                 ph_in[12].rg = REG_LSTAR;
    else                                                ph_in[12].rg = REG_RSTAR;
    star12 = (ph_in[12].rg == REG_LSTAR) || (ph_in[12].rg == REG_RSTAR);
    left12 = (ph_in[12].rg == REG_LEFT) || (ph_in[12].rg == REG_LSTAR);
    ph_in[12].ok = ph_out[11].ok && !(star12 && u11dz);
    ph_in[12].s  = left12 ? ph_out[11].sl  : ph_out[11].sr;
    ph_in[12].d  = left12 ? ph_out[11].dl  : ph_out[11].dr;
    ph_in[12].un = left12 ? ph_out[11].unl : ph_out[11].unr;
    ph_in[12].ut = left12 ? ph_out[11].utl : ph_out[11].utr;
    ph_in[12].fm = left12 ? ph_out[11].fml : ph_out[11].fmr;
    ph_in[12].fx = left12 ? ph_out[11].fxl : ph_out[11].fxr;
    ph_in[12].ft = left12 ? ph_out[11].ftl : ph_out[11].ftr;
    // d*(s-un) is the negated a or b term
    ph_in[12].hn = left12 ? -ph_out[11].b : -ph_out[11].a;
    ph_in[12].sd = qsub(ph_in[12].s, u11q);
  end

  hsw_div u_d12 (.clk(clk), .en(en), .a(ph_in[12].hn), .b(ph_in[12].sd), .q(u12q),
                 .dz(u12dz));

  always_comb begin
    ph_in[13]     = ph_out[12];
    star13        = (ph_out[12].rg == REG_LSTAR) || (ph_out[12].rg == REG_RSTAR);
    ph_in[13].hst = u12q;
    ph_in[13].ok  = ph_out[12].ok && !(star13 && u12dz);
  end

  hsw_mul u_m13_0 (.clk(clk), .en(en), .a(ph_in[13].hst), .b(ph_in[13].ss), .p(u13[0]));
  hsw_mul u_m13_1 (.clk(clk), .en(en), .a(ph_in[13].hst), .b(ph_in[13].ut), .p(u13[1]));
  hsw_mul u_m13_2 (.clk(clk), .en(en), .a(ph_in[13].d),   .b(ph_in[13].un), .p(u13[2]));
  hsw_mul u_m13_3 (.clk(clk), .en(en), .a(ph_in[13].d),   .b(ph_in[13].ut), .p(u13[3]));

  always_comb begin
    ph_in[14]    = ph_out[13];
    ph_in[14].e1 = qsub(ph_out[13].hst, ph_out[13].d);
    ph_in[14].e2 = qsub(u13[0], u13[2]);
    ph_in[14].e3 = qsub(u13[1], u13[3]);
  end

  hsw_mul u_m14_0 (.clk(clk), .en(en), .a(ph_in[14].s), .b(ph_in[14].e1), .p(u14[0]));
  hsw_mul u_m14_1 (.clk(clk), .en(en), .a(ph_in[14].s), .b(ph_in[14].e2), .p(u14[1]));
  hsw_mul u_m14_2 (.clk(clk), .en(en), .a(ph_in[14].s), .b(ph_in[14].e3), .p(u14[2]));

  always_comb begin
    lst      = ph_out[14];
    star_fin = (lst.rg == REG_LSTAR) || (lst.rg == REG_RSTAR);
    fin_m    = star_fin ? qadd(lst.fm, u14[0]) : lst.fm;
    fin_x    = star_fin ? qadd(lst.fx, u14[1]) : lst.fx;
    fin_t    = star_fin ? qadd(lst.ft, u14[2]) : lst.ft;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= lst.vld;
    end
    if (en) begin
      if (!lst.ok) begin
        out_tdata_r <= '0;
        out_tuser_r <= '0;
      end else begin
        // swap momentum components back for the y axis
        out_tdata_r <= {out48(lst.yax ? fin_x : fin_t),
                        out48(lst.yax ? fin_t : fin_x),
                        out48(fin_m)};
        out_tuser_r <= {1'b1, lst.rg};
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> (out_tdata == '0 && out_tuser[1:0] == REG_LEFT))
    else $error("invalid beat carries nonzero payload");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(ph_out[NPH-1].vld))
    else $error("pipeline moved during output stall");

  a_zero_grav: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && grav_r == '0) |-> !out_tuser[2])
    else $error("valid result with zero gravity");

endmodule

`default_nettype wire

FILE: src/hsw_mul.sv
// Pipelined saturating Q.16 multiplier built from 32x32 partial products.
// Depends on hsw_pkg.
`default_nettype none

module hsw_mul import hsw_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q_t   a,
  input  q_t   b,
  output q_t   p
);

  logic [63:0]  am_r, bm_r;
  logic [2:0]   neg_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         sat_r;
  logic [61:0]  m_r;
  q_t           p_r;
  logic [127:0] sum;

  always_comb begin
    sum = {64'b0, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0} + {p11_r, 64'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r  <= a[63] ? 64'(-a) : 64'(a);
      bm_r  <= b[63] ? 64'(-b) : 64'(b);
      neg_r <= {neg_r[1:0], a[63] ^ b[63]};
      p00_r <= {32'b0, am_r[31:0]}  * {32'b0, bm_r[31:0]};
      p01_r <= {32'b0, am_r[31:0]}  * {32'b0, bm_r[63:32]};
      p10_r <= {32'b0, am_r[63:32]} * {32'b0, bm_r[31:0]};
      p11_r <= {32'b0, am_r[63:32]} * {32'b0, bm_r[63:32]};
      sat_r <= |sum[127:78];
      m_r   <= sum[77:16];
      if (sat_r) p_r <= neg_r[2] ? -QLIM : QLIM;
      else       p_r <= neg_r[2] ? -q_t'({2'b0, m_r}) : q_t'({2'b0, m_r});
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

FILE: src/hsw_div.sv
// Pipelined saturating Q.16 divider: restoring division, four quotient bits per stage.
// Depends on hsw_pkg.
`default_nettype none

module hsw_div import hsw_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q_t   a,
  input  q_t   b,
  output q_t   q,
  output logic dz
);

  typedef struct packed {
    logic [63:0] r;
    logic [63:0] n;
    logic [63:0] qa;
    logic [63:0] d;
    logic        neg;
    logic        ovr;
    logic        dz;
  } dst_t;

  dst_t        st_r [DIV_NST+1];
  dst_t        st0;
  logic [63:0] ua, ud;
  q_t          q_r;
  logic        dz_r;

  function automatic dst_t div_steps(input dst_t s);
    dst_t o;
    o = s;
    for (int i = 0; i < DIV_SPS; i++) begin
      o.r = {o.r[62:0], o.n[63]};
      o.n = {o.n[62:0], 1'b0};
      if (o.r >= o.d) begin
        o.r  = o.r - o.d;
        o.qa = {o.qa[62:0], 1'b1};
      end else begin
        o.qa = {o.qa[62:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_comb begin
    ua      = a[63] ? 64'(-a) : 64'(a);
    ud      = b[63] ? 64'(-b) : 64'(b);
    st0.r   = {49'b0, ua[62:48]};
    st0.n   = {ua[47:0], 16'b0};
    st0.qa  = '0;
    st0.d   = ud;
    st0.neg = a[63] ^ b[63];
    st0.dz  = (b == '0);
    // quotient reaches 2^62 exactly when the dividend holds d shifted up by 46
    st0.ovr = ((ua >> 46) >= ud);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0;
      for (int s = 1; s <= DIV_NST; s++) st_r[s] <= div_steps(st_r[s-1]);
      dz_r <= st_r[DIV_NST].dz;
      if (st_r[DIV_NST].dz)       q_r <= '0;
      else if (st_r[DIV_NST].ovr) q_r <= st_r[DIV_NST].neg ? -QLIM : QLIM;
      else if (st_r[DIV_NST].neg) q_r <= -q_t'(st_r[DIV_NST].qa);
      else                        q_r <= q_t'(st_r[DIV_NST].qa);
    end
  end

  assign q  = q_r;
  assign dz = dz_r;

endmodule

`default_nettype wire

FILE: src/hsw_sqrt.sv
// Pipelined Q.16 square root, floor(sqrt(a * 2^16)), two radicand bits per step, four steps a stage.
// Depends on hsw_pkg.
`default_nettype none

module hsw_sqrt import hsw_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q_t   a,
  output q_t   r
);

  typedef struct packed {
    logic [47:0] rem;
    logic [39:0] root;
    logic [79:0] x;
  } sst_t;

  sst_t st_r [SQRT_NST+1];
  sst_t st0;

  function automatic sst_t sqrt_steps(input sst_t s);
    sst_t        o;
    logic [47:0] trial;
    o = s;
    for (int i = 0; i < SQRT_SPS; i++) begin
      o.rem = {o.rem[45:0], o.x[79:78]};
      o.x   = {o.x[77:0], 2'b00};
      trial = {6'b0, o.root, 2'b01};
      if (o.rem >= trial) begin
        o.rem  = o.rem - trial;
        o.root = {o.root[38:0], 1'b1};
      end else begin
        o.root = {o.root[38:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_comb begin
    st0.rem  = '0;
    st0.root = '0;
    st0.x    = (a <= 0) ? 80'b0 : {2'b0, a[61:0], 16'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0;
      for (int s = 1; s <= SQRT_NST; s++) st_r[s] <= sqrt_steps(st_r[s-1]);
    end
  end

  assign r = q_t'({24'b0, st_r[SQRT_NST].root});

endmodule

`default_nettype wire

FILE: dv/hllc_shallow_water_flux_test.sv
// Self-checking testbench for hllc_shallow_water_flux: directed interfaces, then random ones
// under several gravity settings, each beat checked against literal or predicted Q.16 flux.
// Depends on hsw_pkg and the hllc_shallow_water_flux RTL.
`default_nettype none

module hllc_shallow_water_flux_test import hsw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam q_t FX_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam q_t FX_ONE = 64'sd65536;
  localparam q_t FX_HALF = 64'sd32768;
  localparam q_t FX_QUARTER = 64'sd16384;
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PER_PHASE = 72;
  localparam int MAX_REPORTS = 10;
  localparam logic [30:0] G_ONE = 31'd65536;
  localparam logic [30:0] G_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic        op;
    logic [30:0] dl;
    logic [31:0] vxl, vyl;
    logic [30:0] dr;
    logic [31:0] vxr, vyr;
  } iface_t;

  typedef struct packed {
    logic [47:0] mass, xmom, ymom;
    region_t     region;
    logic        ok;
  } flux_t;

  typedef struct packed {
    iface_t item;
    logic   literal;
    flux_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [30:0] cfg_data;
  logic in_tvalid, in_tready;
  logic [IN_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid, out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic [USR_W-1:0] out_tuser;

  hllc_shallow_water_flux dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [30:0] gravity_q;
  logic        div_fault;
  flux_t       flux_pending[$];
  dir_row_t    dir_rows[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          burst_mode = 1'b0;

  // ---------------- Q.16 arithmetic for the predictor ----------------
  function automatic q_t fx_sat(input logic signed [65:0] v);
    if (v > FX_LIM) return FX_LIM;
    if (v < -FX_LIM) return -FX_LIM;
    return v[63:0];
  endfunction

  function automatic q_t fx_add(input q_t a, input q_t b);
    return fx_sat(66'(a) + 66'(b));
  endfunction

  function automatic q_t fx_sub(input q_t a, input q_t b);
    return fx_sat(66'(a) - 66'(b));
  endfunction

  function automatic logic [63:0] fx_mag(input q_t a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic q_t fx_mul(input q_t a, input q_t b);
    logic [127:0] p;
    q_t m;
    p = 128'(fx_mag(a)) * 128'(fx_mag(b));
    m = (p[127:78] != 0) ? FX_LIM : q_t'(p[79:16]);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic q_t fx_div(input q_t a, input q_t b);
    logic [127:0] n, quo;
    q_t m;
    if (b == 0) begin
      div_fault = 1'b1;
      return 0;
    end
    n = 128'(fx_mag(a)) << 16;
    quo = n / 128'(fx_mag(b));
    m = (quo >= (128'd1 << 62)) ? FX_LIM : q_t'(quo[63:0]);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic q_t fx_sqrt(input q_t a);
    logic [127:0] t;
    logic [63:0] r, c;
    if (a <= 0) return 0;
    t = 128'(a) << 16;
    r = 0;
    for (int i = 39; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (128'(c) * 128'(c) <= t) r = c;
    end
    return q_t'(r);
  endfunction

  function automatic q_t shock_corr(input q_t hs, input q_t d);
    q_t p;
    if (hs <= d) return FX_ONE;
    p = fx_mul(fx_mul(FX_HALF, fx_add(hs, d)), hs);
    return fx_sqrt(fx_div(fx_div(p, d), d));
  endfunction

  function automatic logic [47:0] sat48(input q_t v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return 48'h8000_0000_0000;
    return v[47:0];
  endfunction

  // physical flux into (m, n, t), then optionally the star correction
  function automatic void phys(input q_t d, un, ut, g, output q_t m, n, t);
    m = fx_mul(d, un);
    n = fx_add(fx_mul(m, un), fx_mul(FX_HALF, fx_mul(g, fx_mul(d, d))));
    t = fx_mul(m, ut);
  endfunction

  function automatic void star(input q_t s, d, un, ut, ss, inout q_t m, n, t);
    q_t hst;
    hst = fx_div(fx_mul(d, fx_sub(s, un)), fx_sub(s, ss));
    m = fx_add(m, fx_mul(s, fx_sub(hst, d)));
    n = fx_add(n, fx_mul(s, fx_sub(fx_mul(hst, ss), fx_mul(d, un))));
    t = fx_add(t, fx_mul(s, fx_sub(fx_mul(hst, ut), fx_mul(d, ut))));
  endfunction

  function automatic flux_t hllc_flux(input iface_t it, input logic [30:0] grav);
    q_t g, dl, dr, unl, utl, unr, utr, cl, cr, t, hs, sl, sr, a, b, ss;
    q_t ml, nl, tl, mr, nr, tr, m, n, tt;
    flux_t f;
    div_fault = 1'b0;
    g = q_t'(grav);
    dl = q_t'(it.dl);
    dr = q_t'(it.dr);
    unl = it.op ? q_t'($signed(it.vyl)) : q_t'($signed(it.vxl));
    utl = it.op ? q_t'($signed(it.vxl)) : q_t'($signed(it.vyl));
    unr = it.op ? q_t'($signed(it.vyr)) : q_t'($signed(it.vxr));
    utr = it.op ? q_t'($signed(it.vxr)) : q_t'($signed(it.vyr));
    cl = fx_sqrt(fx_mul(g, dl));
    cr = fx_sqrt(fx_mul(g, dr));
    t = fx_add(fx_mul(FX_HALF, fx_add(cl, cr)), fx_mul(FX_QUARTER, fx_sub(unl, unr)));
    hs = fx_div(fx_mul(t, t), g);
    sl = fx_sub(unl, fx_mul(cl, shock_corr(hs, dl)));
    sr = fx_add(unr, fx_mul(cr, shock_corr(hs, dr)));
    phys(dl, unl, utl, g, ml, nl, tl);
    phys(dr, unr, utr, g, mr, nr, tr);
    if (sl >= 0) begin
      f.region = REG_LEFT; m = ml; n = nl; tt = tl;
    end else if (sr <= 0) begin
      f.region = REG_RIGHT; m = mr; n = nr; tt = tr;
    end else begin
      a = fx_mul(dr, fx_sub(unr, sr));
      b = fx_mul(dl, fx_sub(unl, sl));
      ss = fx_div(fx_sub(fx_mul(sl, a), fx_mul(sr, b)), fx_sub(a, b));
      if (ss >= 0) begin
        f.region = REG_LSTAR; m = ml; n = nl; tt = tl;
        star(sl, dl, unl, utl, ss, m, n, tt);
      end else begin
        f.region = REG_RSTAR; m = mr; n = nr; tt = tr;
        star(sr, dr, unr, utr, ss, m, n, tt);
      end
    end
    if (div_fault) return '0;
    f.mass = sat48(m);
    f.xmom = sat48(it.op ? tt : n);
    f.ymom = sat48(it.op ? n : tt);
    f.ok = 1'b1;
    return f;
  endfunction

  // ---------------- stimulus ----------------
  function automatic void add_row(input logic op, input logic [30:0] dl,
                                  input logic [31:0] vxl, vyl, input logic [30:0] dr,
                                  input logic [31:0] vxr, vyr, input logic literal,
                                  input flux_t want);
    dir_row_t r;
    r.item = '{op, dl, vxl, vyl, dr, vxr, vyr};
    r.literal = literal;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] rand_vel();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return 32'($urandom_range(0, 40 << 16)) - 32'(20 << 16);
    if (k < 9) return $urandom();
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic logic [30:0] rand_depth();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 31'd0;
    if (k < 15) return 31'($urandom_range(1, 10 << 16));
    if (k < 19) return 31'($urandom());
    return G_MAX;
  endfunction

  function automatic iface_t rand_item();
    iface_t it;
    it.op = 1'($urandom_range(0, 1));
    it.dl = rand_depth();
    it.vxl = rand_vel();
    it.vyl = rand_vel();
    it.dr = rand_depth();
    it.vxr = rand_vel();
    it.vyr = rand_vel();
    return it;
  endfunction

  function automatic int pick_gap();
    int k;
    if (burst_mode) return 0;
    k = $urandom_range(0, 19);
    if (k < 12) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input iface_t it, input logic literal, input flux_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {2'b00, it.vyr, it.vxr, it.dr, it.vyl, it.vxl, it.dl};
    do @(posedge clk); while (!in_tready);
    flux_pending.push_back(literal ? want : hllc_flux(it, gravity_q));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (flux_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gravity(input logic [30:0] g);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gravity_q = g;
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    flux_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mass = out_tdata[47:0];
      got.xmom = out_tdata[95:48];
      got.ymom = out_tdata[143:96];
      got.region = region_t'(out_tuser[1:0]);
      got.ok = out_tuser[2];
      if (flux_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected flux beat: %p", got);
      end else begin
        want = flux_pending.pop_front();
        if (got.mass !== want.mass || got.xmom !== want.xmom || got.ymom !== want.ymom ||
            got.region !== want.region || got.ok !== want.ok) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("flux mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hllc_shallow_water_flux_test: FAIL");
      $finish;
    end
  end

  // result side: long ready stretches, short and occasional long stalls
  initial begin
    int k;
    forever begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (k < 9) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [30:0] grav_plan[7];
    flux_t zero_ok, invalid;
    zero_ok = '0;
    zero_ok.ok = 1'b1;
    invalid = '0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    gravity_q = GRAV_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // still water of zero depth: left region, no flux
    add_row(0, 0, 0, 0, 0, 0, 0, 1, zero_ok);
    add_row(1, 0, 0, 0, 0, 0, 0, 1, zero_ok);
    // dry left cell behind a shock, then extreme depths and velocities
    add_row(0, 0, 0, 0, 31'd65536, 0, 0, 1, invalid);
    add_row(1, 0, 0, 0, 31'd65536, 0, 0, 1, invalid);
    add_row(0, G_MAX, 0, 0, G_MAX, 0, 0, 0, '0);
    add_row(0, G_MAX, 0, 0, 0, 0, 0, 0, '0);
    add_row(1, 0, 0, 0, G_MAX, 0, 0, 0, '0);
    add_row(0, 31'd65536, 32'h7FFF_FFFF, 0, 31'd65536, 32'h8000_0000, 0, 0, '0);
    add_row(0, 31'd65536, 32'h8000_0000, 0, 31'd65536, 32'h7FFF_FFFF, 0, 0, '0);
    add_row(1, 31'd65536, 0, 32'h7FFF_FFFF, 31'd65536, 0, 32'h8000_0000, 0, '0);
    add_row(1, 31'd65536, 32'h7FFF_FFFF, 32'h8000_0000, 31'd65536, 32'h8000_0000,
            32'h7FFF_FFFF, 0, '0);
    // dam break, supersonic both ways, rarefaction, shear
    add_row(0, 31'd131072, 0, 0, 31'd65536, 0, 0, 0, '0);
    add_row(1, 31'd65536, 0, 0, 31'd131072, 0, 0, 0, '0);
    add_row(0, 31'd65536, 32'd1310720, 32'd65536, 31'd65536, 32'd1310720, 0, 0, '0);
    add_row(0, 31'd65536, -32'sd1310720, 0, 31'd65536, -32'sd1310720, 32'd65536, 0, '0);
    add_row(0, 31'd65536, -32'sd131072, 0, 31'd65536, 32'd131072, 0, 0, '0);
    add_row(0, 31'd65536, 32'd32768, 32'd65536, 31'd65536, -32'sd16384, 32'd98304, 0, '0);
    add_row(1, 31'd65536, 32'd98304, -32'sd16384, 31'd65536, 32'd65536, 32'd32768, 0, '0);
    add_row(0, G_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, G_MAX, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 0, '0);
    add_row(1, G_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, G_MAX, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 0, '0);
    add_row(0, 31'd1, 32'd1, 32'hFFFF_FFFF, 31'd1, 32'hFFFF_FFFF, 32'd1, 0, '0);
    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].literal, dir_rows[i].want);

    grav_plan = '{31'd0, G_MAX, G_ONE, 31'd1, 31'($urandom()), 31'd6553, GRAV_RST};
    foreach (grav_plan[p]) begin
      drain();
      write_gravity(grav_plan[p]);
      burst_mode = (p % 3) == 1;
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        // hold the sender until the pipeline is empty
        if (p == 3 && i == RAND_PER_PHASE / 2) drain();
        send(rand_item(), 1'b0, '0);
      end
    end
    drain();

    if (mismatches == 0 && flux_pending.size() == 0)
      $display("hllc_shallow_water_flux_test: PASS");
    else
      $display("hllc_shallow_water_flux_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
